>>> design/line_intersection_2d_assert.svh
// Assertion macros used by the line intersection RTL.
// Each macro expects clk and rst in scope.
`ifndef LINE_INTERSECTION_2D_ASSERT_SVH
`define LINE_INTERSECTION_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define LI2D_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define LI2D_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LI2D_IMPLIES(lbl, pre, post, msg)
`define LI2D_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> design/lix_pkg.sv
package lix_pkg;

  localparam int COORD_BITS_DEF = 32;

  // per-request flags carried alongside the quotient lanes
  typedef struct packed {
    logic par;
    logic neg_x;
    logic neg_y;
    logic big_x;
    logic big_y;
  } lix_flags_t;

endpackage

>>> design/lix_div.sv
module lix_div
  import lix_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [3*COORD_BITS+3:0]    in_num_x,
  input  logic [3*COORD_BITS+3:0]    in_num_y,
  input  logic [2*COORD_BITS+2:0]    in_den,
  input  lix_flags_t                 in_flags,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COORD_BITS-1:0]      out_q_x,
  output logic [COORD_BITS-1:0]      out_q_y,
  output lix_flags_t                 out_flags
);

  localparam int W  = COORD_BITS;
  localparam int NW = 3 * W + 4;
  localparam int DW = 2 * W + 3;

  logic             v     [W];
  logic             rdy   [W];
  logic [NW-1:0]    rem_x [W];
  logic [NW-1:0]    rem_y [W];
  logic [W-1:0]     q_x   [W];
  logic [W-1:0]     q_y   [W];
  logic [DW-1:0]    den   [W];
  lix_flags_t       flg   [W];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int SH = W - 1 - k;
    localparam logic [W-1:0] QBIT = W'(1) << SH;

    logic             pv;
    logic [NW-1:0]    prx;
    logic [NW-1:0]    pry;
    logic [W-1:0]     pqx;
    logic [W-1:0]     pqy;
    logic [DW-1:0]    pd;
    lix_flags_t       pf;
    logic [NW:0]      tx;
    logic [NW:0]      ty;
    logic [NW-1:0]    dsh;

    if (k == 0) begin : g_first
      assign pv  = in_valid;
      assign prx = in_num_x;
      assign pry = in_num_y;
      assign pqx = '0;
      assign pqy = '0;
      assign pd  = in_den;
      assign pf  = in_flags;
    end else begin : g_next
      assign pv  = v[k-1];
      assign prx = rem_x[k-1];
      assign pry = rem_y[k-1];
      assign pqx = q_x[k-1];
      assign pqy = q_y[k-1];
      assign pd  = den[k-1];
      assign pf  = flg[k-1];
    end

    if (k == W - 1) begin : g_last_rdy
      assign rdy[k] = !v[k] || out_ready;
    end else begin : g_mid_rdy
      assign rdy[k] = !v[k] || rdy[k+1];
    end

    assign dsh = NW'(pd) << SH;
    assign tx  = {1'b0, prx} - {1'b0, dsh};
    assign ty  = {1'b0, pry} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        // keep the trial difference only when it did not borrow
        rem_x[k] <= tx[NW] ? prx : tx[NW-1:0];
        rem_y[k] <= ty[NW] ? pry : ty[NW-1:0];
        q_x[k]   <= tx[NW] ? pqx : (pqx | QBIT);
        q_y[k]   <= ty[NW] ? pqy : (pqy | QBIT);
        den[k]   <= pd;
        flg[k]   <= pf;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[W-1];
  assign out_q_x   = q_x[W-1];
  assign out_q_y   = q_y[W-1];
  assign out_flags = flg[W-1];

endmodule

>>> design/line_intersection_2d.sv
// Channel  Direction  tdata (low bit up)                              tuser
// s_       in         line1_start_x, line1_start_y, line1_end_x,      -
//                     line1_end_y, line2_start_x, line2_start_y,
//                     line2_end_x, line2_end_y
// m_       out        cross_x, cross_y                                parallel, overflow
//
// One line pair accepted per cycle while the output is not stalled.
// The depth is set by the restoring divider, one quotient bit per stage, behind seven
// stages of differences, products, sums, partial products, magnitudes and a range check.
// Every stage has its own valid bit and ready, so bubbles close up and a
// stalled output holds without losing or repeating a request.
// Synchronous reset clears the valid bits only.
`include "line_intersection_2d_assert.svh"

module line_intersection_2d
  import lix_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // line1_start_x, line1_start_y, line1_end_x, line1_end_y,
  // line2_start_x, line2_start_y, line2_end_x, line2_end_y
  input  logic [8*COORD_BITS-1:0]                s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // cross_x, cross_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
  // parallel, overflow
  output logic [1:0]                             m_tuser
);

  localparam int W   = COORD_BITS;
  localparam int AW  = W + 1;
  localparam int CW  = 2 * W + 2;
  localparam int CL  = W + 1;
  localparam int CH  = CW - CL;
  localparam int DW  = 2 * W + 3;
  localparam int NW  = 3 * W + 4;
  localparam int PL  = AW + CL + 1;
  localparam int PH  = AW + CH;
  localparam int TDW = ((2 * W + 7) / 8) * 8;

  logic signed [W-1:0] pin [8];
  for (genvar i = 0; i < 8; i++) begin : g_unpack
    assign pin[i] = s_tdata[i*W +: W];
  end

  logic v1, v2, v3, v4, v5, v6, v7, vo;
  logic r1, r2, r3, r4, r5, r6, r7, ro;
  logic div_rdy, div_v;

  assign ro = !vo || m_tready;
  assign r7 = !v7 || div_rdy;
  assign r6 = !v6 || r7;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; vo <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
      if (r7) v7 <= v6;
      if (ro) vo <= div_v;
    end
  end

  // stage 1: line coefficients
  logic signed [AW-1:0] a1_1, b1_1, a2_1, b2_1;
  logic signed [W-1:0]  sx1_1, sy1_1, sx2_1, sy2_1;
  always_ff @(posedge clk) begin
    if (r1) begin
      a1_1  <= AW'(pin[3]) - AW'(pin[1]);
      b1_1  <= AW'(pin[0]) - AW'(pin[2]);
      a2_1  <= AW'(pin[7]) - AW'(pin[5]);
      b2_1  <= AW'(pin[4]) - AW'(pin[6]);
      sx1_1 <= pin[0];
      sy1_1 <= pin[1];
      sx2_1 <= pin[4];
      sy2_1 <= pin[5];
    end
  end

  // stage 2: products for c and det
  logic signed [AW+W-1:0]  ax1_2, by1_2, ax2_2, by2_2;
  logic signed [2*AW-1:0]  ab_2, ba_2;
  logic signed [AW-1:0]    a1_2, b1_2, a2_2, b2_2;
  always_ff @(posedge clk) begin
    if (r2) begin
      ax1_2 <= a1_1 * sx1_1;
      by1_2 <= b1_1 * sy1_1;
      ax2_2 <= a2_1 * sx2_1;
      by2_2 <= b2_1 * sy2_1;
      ab_2  <= a1_1 * b2_1;
      ba_2  <= a2_1 * b1_1;
      a1_2  <= a1_1;
      b1_2  <= b1_1;
      a2_2  <= a2_1;
      b2_2  <= b2_1;
    end
  end

  // stage 3: c and det
  logic signed [CW-1:0] c1_3, c2_3;
  logic signed [DW-1:0] det_3;
  logic signed [AW-1:0] a1_3, b1_3, a2_3, b2_3;
  always_ff @(posedge clk) begin
    if (r3) begin
      c1_3  <= CW'(ax1_2) + CW'(by1_2);
      c2_3  <= CW'(ax2_2) + CW'(by2_2);
      det_3 <= DW'(ab_2) - DW'(ba_2);
      a1_3  <= a1_2;
      b1_3  <= b1_2;
      a2_3  <= a2_2;
      b2_3  <= b2_2;
    end
  end

  // stage 4: numerator products split over the halves of c
  logic signed [CL:0]   c1l, c2l;
  logic signed [CH-1:0] c1h, c2h;
  assign c1l = {1'b0, c1_3[CL-1:0]};
  assign c2l = {1'b0, c2_3[CL-1:0]};
  assign c1h = c1_3[CW-1:CL];
  assign c2h = c2_3[CW-1:CL];

  logic signed [PL-1:0] b2c1l, b1c2l, a1c2l, a2c1l;
  logic signed [PH-1:0] b2c1h, b1c2h, a1c2h, a2c1h;
  logic signed [DW-1:0] det_4;
  always_ff @(posedge clk) begin
    if (r4) begin
      b2c1l <= b2_3 * c1l;
      b1c2l <= b1_3 * c2l;
      a1c2l <= a1_3 * c2l;
      a2c1l <= a2_3 * c1l;
      b2c1h <= b2_3 * c1h;
      b1c2h <= b1_3 * c2h;
      a1c2h <= a1_3 * c2h;
      a2c1h <= a2_3 * c1h;
      det_4 <= det_3;
    end
  end

  // stage 5: numerators
  logic signed [NW-1:0] nx_5, ny_5;
  logic signed [DW-1:0] det_5;
  always_ff @(posedge clk) begin
    if (r5) begin
      nx_5  <= (NW'(b2c1h) <<< CL) + NW'(b2c1l) - (NW'(b1c2h) <<< CL) - NW'(b1c2l);
      ny_5  <= (NW'(a1c2h) <<< CL) + NW'(a1c2l) - (NW'(a2c1h) <<< CL) - NW'(a2c1l);
      det_5 <= det_4;
    end
  end

  // stage 6: magnitudes and signs
  logic [NW-1:0] ax_6, ay_6;
  logic [DW-1:0] ad_6;
  lix_flags_t    f_6;
  always_ff @(posedge clk) begin
    if (r6) begin
      ax_6      <= nx_5[NW-1] ? NW'(-nx_5) : NW'(nx_5);
      ay_6      <= ny_5[NW-1] ? NW'(-ny_5) : NW'(ny_5);
      ad_6      <= det_5[DW-1] ? DW'(-det_5) : DW'(det_5);
      f_6.par   <= (det_5 == '0);
      f_6.neg_x <= nx_5[NW-1] ^ det_5[DW-1];
      f_6.neg_y <= ny_5[NW-1] ^ det_5[DW-1];
      f_6.big_x <= 1'b0;
      f_6.big_y <= 1'b0;
    end
  end

  // stage 7: flag quotients that cannot fit in COORD_BITS magnitude bits
  logic [NW-1:0] ax_7, ay_7;
  logic [DW-1:0] ad_7;
  lix_flags_t    f_7;
  logic [NW-1:0] dlim;
  assign dlim = NW'(ad_6) << W;
  always_ff @(posedge clk) begin
    if (r7) begin
      ax_7      <= ax_6;
      ay_7      <= ay_6;
      ad_7      <= ad_6;
      f_7.par   <= f_6.par;
      f_7.neg_x <= f_6.neg_x;
      f_7.neg_y <= f_6.neg_y;
      f_7.big_x <= (ax_6 >= dlim);
      f_7.big_y <= (ay_6 >= dlim);
    end
  end

  logic [W-1:0] qx, qy;
  lix_flags_t   fq;

  lix_div #(
    .COORD_BITS (W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .in_ready  (div_rdy),
    .in_num_x  (ax_7),
    .in_num_y  (ay_7),
    .in_den    (ad_7),
    .in_flags  (f_7),
    .out_valid (div_v),
    .out_ready (ro),
    .out_q_x   (qx),
    .out_q_y   (qy),
    .out_flags (fq)
  );

  // saturate to the signed coordinate range
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic         sat_x, sat_y;
  logic [W-1:0] vx, vy;
  always_comb begin
    if (fq.neg_x) begin
      sat_x = fq.big_x || (qx[W-1] && (qx[W-2:0] != '0));
      vx    = sat_x ? SMIN : W'(-qx);
    end else begin
      sat_x = fq.big_x || qx[W-1];
      vx    = sat_x ? SMAX : qx;
    end
    if (fq.neg_y) begin
      sat_y = fq.big_y || (qy[W-1] && (qy[W-2:0] != '0));
      vy    = sat_y ? SMIN : W'(-qy);
    end else begin
      sat_y = fq.big_y || qy[W-1];
      vy    = sat_y ? SMAX : qy;
    end
  end

  logic [W-1:0] x_o, y_o;
  logic         par_o, ovf_o;
  always_ff @(posedge clk) begin
    if (ro) begin
      x_o   <= fq.par ? '0 : vx;
      y_o   <= fq.par ? '0 : vy;
      par_o <= fq.par;
      ovf_o <= !fq.par && (sat_x || sat_y);
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = TDW'({y_o, x_o});
  assign m_tuser  = {ovf_o, par_o};

  `LI2D_IMPLIES(a_par_clean, vo && par_o, x_o == '0 && y_o == '0 && !ovf_o, "parallel not clean")
  `LI2D_NEXT(a_front_hold, v7 && !div_rdy, v7, "front request dropped while divider stalled")
  `LI2D_IMPLIES(a_empty_ready, !v1, s_tready, "input stalled with empty first stage")
  `LI2D_NEXT(a_take_in, s_tvalid && s_tready, v1, "accepted request not captured")

endmodule

>>> dv/line_intersection_2d_tb.sv
`timescale 1ns / 100ps

module line_intersection_2d_tb
  import lix_pkg::*;
();

  localparam int CW = COORD_BITS_DEF;
  localparam int MW = ((2 * CW + 7) / 8) * 8;
  localparam int LATENCY = CW + 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
    logic                 par;
    logic                 ovf;
  } crossing_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [8*CW-1:0] s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [MW-1:0]  m_tdata;
  logic [1:0]     m_tuser;

  crossing_t crossings_due[$];
  int        errors = 0;
  int        pairs_sent = 0;
  int        results_seen = 0;
  int        parallel_seen = 0;
  int        overflow_seen = 0;
  int        idle_cycles = 0;
  int        rx_hold = 0;
  bit        rx_stall_on = 1'b1;

  line_intersection_2d dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // signed quotient, truncated toward zero, saturated to the coordinate range
  function automatic logic signed [CW-1:0] sat_quot(input logic signed [255:0] num,
                                                   input logic signed [255:0] den,
                                                   inout logic ovf);
    logic signed [255:0] q;
    logic signed [255:0] hi;
    logic signed [255:0] lo;
    begin
      q  = num / den;
      hi = (256'sd1 <<< (CW - 1)) - 1;
      lo = -(256'sd1 <<< (CW - 1));
      if (q > hi) begin
        ovf = 1'b1;
        sat_quot = hi[CW-1:0];
      end else if (q < lo) begin
        ovf = 1'b1;
        sat_quot = lo[CW-1:0];
      end else begin
        sat_quot = q[CW-1:0];
      end
    end
  endfunction

  function automatic crossing_t solve_crossing(input logic [8*CW-1:0] d);
    logic signed [255:0] p[8];
    logic signed [255:0] a1, b1, c1, a2, b2, c2, det;
    crossing_t r;
    logic ovf;
    begin
      for (int i = 0; i < 8; i++) p[i] = 256'(signed'(d[i*CW +: CW]));
      a1  = p[3] - p[1];
      b1  = p[0] - p[2];
      a2  = p[7] - p[5];
      b2  = p[4] - p[6];
      c1  = a1 * p[0] + b1 * p[1];
      c2  = a2 * p[4] + b2 * p[5];
      det = a1 * b2 - a2 * b1;
      r   = '0;
      ovf = 1'b0;
      if (det == 0) begin
        r.par = 1'b1;
      end else begin
        r.x   = sat_quot(b2 * c1 - b1 * c2, det, ovf);
        r.y   = sat_quot(a1 * c2 - a2 * c1, det, ovf);
        r.ovf = ovf;
      end
      solve_crossing = r;
    end
  endfunction

  function automatic int pick_gap();
    begin
      if ($urandom_range(0, 99) < 3) pick_gap = $urandom_range(10, 40);
      else if ($urandom_range(0, 99) < 50) pick_gap = 0;
      else pick_gap = $urandom_range(1, 3);
    end
  endfunction

  task automatic send_pair(input logic [8*CW-1:0] d, input bit gaps);
    int gap;
    begin
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tdata  <= d;
      s_tvalid <= 1'b1;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      crossings_due.push_back(solve_crossing(d));
      pairs_sent++;
      @(negedge clk);
    end
  endtask

  task automatic idle_input();
    begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic [8*CW-1:0] pack_pts(input logic [CW-1:0] v[8]);
    logic [8*CW-1:0] d;
    begin
      for (int i = 0; i < 8; i++) d[i*CW +: CW] = v[i];
      pack_pts = d;
    end
  endfunction

  function automatic logic [CW-1:0] rand_coord(input int mode);
    begin
      case (mode)
        0: rand_coord = $urandom();
        1: rand_coord = CW'(signed'($urandom_range(0, 40)) - 20) <<< 16;
        2: rand_coord = CW'(signed'($urandom_range(0, 4000)) - 2000);
        default: rand_coord = $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}}
                                                   : {1'b1, {(CW-1){1'b0}}};
      endcase
    end
  endfunction

  task automatic test_directed();
    logic [CW-1:0] v[8];
    logic [CW-1:0] maxc, minc, one;
    begin
      maxc = {1'b0, {(CW-1){1'b1}}};
      minc = {1'b1, {(CW-1){1'b0}}};
      one  = CW'(1) << 16;
      // plain crossing of the diagonals
      v = '{0, 0, one, one, 0, one, one, 0};
      send_pair(pack_pts(v), 0);
      // parallel lines
      v = '{0, 0, one, one, one, 0, 2 * one, one};
      send_pair(pack_pts(v), 0);
      // coincident points make a degenerate line
      v = '{one, one, one, one, 0, 0, one, 2 * one};
      send_pair(pack_pts(v), 0);
      // both lines degenerate
      v = '{0, 0, 0, 0, 0, 0, 0, 0};
      send_pair(pack_pts(v), 0);
      // nearly parallel: crossing far out, saturates
      v = '{0, 0, one, 1, 0, one, one, one + 2};
      send_pair(pack_pts(v), 0);
      v = '{0, 0, minc, maxc, 1, 0, 0, 1};
      send_pair(pack_pts(v), 0);
      // extremes of every field, and all-ones fields mixed with zeros
      v = '{maxc, minc, minc, maxc, maxc, maxc, minc, minc};
      send_pair(pack_pts(v), 0);
      v = '{minc, minc, maxc, maxc, minc, maxc, maxc, minc};
      send_pair(pack_pts(v), 0);
      v = '{maxc, maxc, maxc, maxc, minc, minc, minc, minc};
      send_pair(pack_pts(v), 0);
      v = '{{CW{1'b1}}, 0, 0, {CW{1'b1}}, 0, 0, {CW{1'b1}}, {CW{1'b1}}};
      send_pair(pack_pts(v), 0);
      // fractional crossings truncated toward zero
      v = '{0, 0, 3, 1, 0, -CW'(1), 1, 0};
      send_pair(pack_pts(v), 0);
      v = '{-CW'(7), 0, 7, 3, 0, 5, 2, -CW'(9)};
      send_pair(pack_pts(v), 0);
      idle_input();
    end
  endtask

  task automatic test_random(input int count);
    logic [CW-1:0] v[8];
    int mode;
    begin
      for (int n = 0; n < count; n++) begin
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
          v[i] = rand_coord(mode < 4 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : $urandom_range(0, 3));
        // force a share of parallel pairs by copying the first direction
        if ($urandom_range(0, 7) == 0) begin
          v[6] = v[4] + (v[2] - v[0]);
          v[7] = v[5] + (v[3] - v[1]);
        end
        send_pair(pack_pts(v), 1);
      end
      idle_input();
    end
  endtask

  task automatic test_back_to_back(input int count);
    logic [CW-1:0] v[8];
    begin
      rx_stall_on = 1'b0;
      for (int n = 0; n < count; n++) begin
        for (int i = 0; i < 8; i++) v[i] = rand_coord($urandom_range(0, 2));
        send_pair(pack_pts(v), 0);
      end
      idle_input();
    end
  endtask

  // drive the receiver's stalls: mostly short, now and then a long hold
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else if (!rx_stall_on) begin
      m_tready <= 1'b1;
      rx_hold  <= 0;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if ($urandom_range(0, 99) < 2) begin
      m_tready <= 1'b0;
      rx_hold  <= $urandom_range(10, 40);
    end else begin
      m_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // check each result against the oldest prediction
  always @(posedge clk) begin
    crossing_t want, got;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got.x   = m_tdata[CW-1:0];
        got.y   = m_tdata[2*CW-1:CW];
        got.par = m_tuser[0];
        got.ovf = m_tuser[1];
        results_seen++;
        if (got.par) parallel_seen++;
        if (got.ovf) overflow_seen++;
        if (crossings_due.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h par=%b ovf=%b", $time,
                   got.x, got.y, got.par, got.ovf);
          errors++;
        end else begin
          want = crossings_due.pop_front();
          if (got.x !== want.x) begin
            $display("%0t: cross_x expected %h actual %h", $time, want.x, got.x);
            errors++;
          end
          if (got.y !== want.y) begin
            $display("%0t: cross_y expected %h actual %h", $time, want.y, got.y);
            errors++;
          end
          if (got.par !== want.par) begin
            $display("%0t: parallel expected %b actual %b", $time, want.par, got.par);
            errors++;
          end
          if (got.ovf !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(700);
    test_back_to_back(100);
    rx_stall_on = 1'b1;
    while (crossings_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d line pairs, checked %0d results (%0d parallel, %0d saturated).",
             pairs_sent, results_seen, parallel_seen, overflow_seen);
    if (errors == 0 && crossings_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, crossings_due.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
